### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthands for clocked concurrent assertions that are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Expression never holds.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

### rtl/bfcm_pkg.sv
// ----------------------------------------------------------------------------
// bfcm_pkg
// Types, constants and helpers of the clipped 3x3 box filter.
// ----------------------------------------------------------------------------
package bfcm_pkg;

  localparam int MAX_SIZE = 32;
  localparam int COL_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 6;
  localparam int PIX_W    = 8;
  localparam int CSUM_W   = PIX_W + 2;   // three pixels of one column
  localparam int WSUM_W   = PIX_W + 4;   // nine pixels of a window

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

  // APB register map
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_IMAGE_SIZE = 1'b0;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Division by 4, 6 and 9 as multiply by a scaled reciprocal
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] MUL_4 = RECIP_W'(16384);
  localparam logic [RECIP_W-1:0] MUL_6 = RECIP_W'(10923);
  localparam logic [RECIP_W-1:0] MUL_9 = RECIP_W'(7282);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_TAIL,
    ST_FLUSH,
    ST_FTAIL
  } seq_state_e;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_FLUSH,
    KIND_TAIL
  } item_kind_e;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_e;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_word_t;

  typedef struct packed {
    item_kind_e       kind;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             emit;
    logic             three_rows;
    logic             last_burst;
    logic             last_image;
  } stage1_t;

  typedef struct packed {
    logic [WSUM_W-1:0] sum;
    div_e              div;
    logic              last_burst;
    logic              last_image;
  } stage2_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last_burst;
    logic             last_image;
  } out_t;

  // Highest column index for a programmed size, size clamped to 2..MAX_SIZE.
  function automatic logic [COL_W-1:0] last_index(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = size;
    if (n < SIZE_W'(2)) begin
      n = SIZE_W'(2);
    end else if (n > SIZE_W'(MAX_SIZE)) begin
      n = SIZE_W'(MAX_SIZE);
    end
    return COL_W'(n - SIZE_W'(1));
  endfunction

endpackage

### rtl/box_filter_3x3_clipped_mean.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_clipped_mean
// 3x3 mean filter with clipped borders over a square 8-bit raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels of an n x n image enter in raster order on s_axis (one per beat,
//   tdata = pixel). Results leave on m_axis in raster order: tdata = mean,
//   tlast marks the final result released by one input beat, tuser marks the
//   bottom-right result of the image. n comes from register image_size at
//   APB offset 0 (clamped to 2..32); writing it restarts the image. The user
//   must write it only while the block is idle; the block does not enforce it.
//   Pipeline: the result for (r-1, c-1) is issued when pixel (r, c) is
//   taken and passes through s1_q, s2_q and the output FIFO. Throughput:
//   one pixel per clock while tready is high; from row 1 on, the end of a
//   row adds a tail slot for the right-edge result, and the last pixel is
//   followed by a sweep of the line memory for the bottom row.
//   Reset: counters to zero, image_size to 32; the line memory is not
//   cleared, since row 0 always fills it before its contents are used.
//   Stall: results queue in a 4-entry output FIFO; the input holds tready
//   low once queued plus in-flight results reach 4, so the pipeline itself
//   never stops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_filter_3x3_clipped_mean
  import bfcm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // pixel input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
  // result output
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,   // [7:0] smoothed_value
  output logic              m_axis_tlast,   // last_of_burst
  output logic              m_axis_tuser    // last_of_image
);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] image_size_q;
  logic [COL_W-1:0]  last_idx;
  logic              cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign last_idx = last_index(image_size_q);

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_IMAGE_SIZE) begin
      prdata = DATA_W'(image_size_q);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: pixel beats, right-edge tails and the bottom-row sweep
  // --------------------------------------------------------------------------
  seq_state_e        state_q, state_d;
  logic [COL_W-1:0]  row_q, col_q, fx_q;
  logic              tail_three_q, tail_last_q;
  logic              room, in_acc, iss_valid;
  logic              mem_re;
  logic [COL_W-1:0]  mem_raddr;
  stage1_t           s1_d, s1_q;
  logic              s1_valid_q;
  stage2_t           s2_d, s2_q;
  logic              s2_valid_q;
  logic [CNT_W-1:0]  fifo_cnt_q;
  logic [CNT_W:0]    inflight;

  // Every issued slot may yield one result; reserve queue space up front.
  assign inflight = (CNT_W+1)'(fifo_cnt_q) + (CNT_W+1)'(s1_valid_q)
                  + (CNT_W+1)'(s2_valid_q);
  assign room     = inflight < (CNT_W+1)'(FIFO_DEPTH);
  assign in_acc   = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_acc && row_q != '0 && col_q == last_idx) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (room) state_d = tail_last_q ? ST_FLUSH : ST_RUN;
      end
      ST_FLUSH: begin
        if (room && fx_q == last_idx) state_d = ST_FTAIL;
      end
      ST_FTAIL: begin
        if (room) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    s_axis_tready   = 1'b0;
    iss_valid       = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = col_q;
    s1_d.kind       = KIND_PIXEL;
    s1_d.col        = col_q;
    s1_d.pix        = s_axis_tdata;
    s1_d.emit       = 1'b0;
    s1_d.three_rows = 1'b0;
    s1_d.last_burst = 1'b0;
    s1_d.last_image = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        s_axis_tready   = room;
        iss_valid       = s_axis_tvalid & room;
        mem_re          = s_axis_tvalid & room;
        s1_d.emit       = (row_q != '0) && (col_q != '0);
        s1_d.three_rows = row_q > COL_W'(1);
        s1_d.last_burst = col_q != last_idx;
      end
      ST_TAIL: begin
        iss_valid       = room;
        s1_d.kind       = KIND_TAIL;
        s1_d.emit       = 1'b1;
        s1_d.three_rows = tail_three_q;
        s1_d.last_burst = !tail_last_q;
      end
      ST_FLUSH: begin
        iss_valid       = room;
        mem_re          = room;
        mem_raddr       = fx_q;
        s1_d.kind       = KIND_FLUSH;
        s1_d.col        = fx_q;
        s1_d.emit       = fx_q != '0;
      end
      ST_FTAIL: begin
        iss_valid       = room;
        s1_d.kind       = KIND_TAIL;
        s1_d.emit       = 1'b1;
        s1_d.last_burst = 1'b1;
        s1_d.last_image = 1'b1;
      end
      default: begin
        iss_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      image_size_q <= SIZE_RESET;
      row_q        <= '0;
      col_q        <= '0;
      fx_q         <= '0;
      tail_three_q <= 1'b0;
      tail_last_q  <= 1'b0;
    end else if (cfg_wr) begin
      // restart the image on any write to the size register
      if (paddr[ADDR_W-1] == REG_IMAGE_SIZE) begin
        image_size_q <= pwdata[SIZE_W-1:0];
        row_q        <= '0;
        col_q        <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        tail_three_q <= row_q > COL_W'(1);
        tail_last_q  <= row_q == last_idx;
        if (col_q == last_idx) begin
          col_q <= '0;
          row_q <= (row_q == last_idx) ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (state_q == ST_FLUSH && room) begin
        fx_q <= (fx_q == last_idx) ? '0 : fx_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: each word holds {row r-2, row r-1} of one column.
  // Read at issue, written back the cycle after with {row r-1, row r}.
  // --------------------------------------------------------------------------
  line_word_t       line_mem [MAX_SIZE];
  line_word_t       rd_q;
  line_word_t       mem_wdata;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;

  assign mem_we    = s1_valid_q && (s1_q.kind == KIND_PIXEL);
  assign mem_waddr = s1_q.col;
  assign mem_wdata = '{upper: rd_q.middle, middle: s1_q.pix};

  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= line_mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Stage 1: column sum and window of the two previous column sums
  // --------------------------------------------------------------------------
  logic [CSUM_W-1:0] cs_cur, cs1_q, cs2_q;
  logic              is_col, wide_left, three_cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= iss_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_valid) s1_q <= s1_d;
  end

  always_comb begin
    is_col = s1_q.kind != KIND_TAIL;
    if (s1_q.kind == KIND_PIXEL) begin
      cs_cur = CSUM_W'(rd_q.middle) + CSUM_W'(s1_q.pix)
             + (s1_q.three_rows ? CSUM_W'(rd_q.upper) : '0);
    end else begin
      // sweep: bottom row has only the row above it
      cs_cur = CSUM_W'(rd_q.upper) + CSUM_W'(rd_q.middle);
    end
    // tail: window is columns n-2 and n-1, both already in the shift pair
    wide_left  = is_col ? (s1_q.col > COL_W'(1)) : 1'b1;
    three_cols = is_col && (s1_q.col > COL_W'(1));

    s2_d.sum = WSUM_W'(cs1_q) + (wide_left ? WSUM_W'(cs2_q) : '0)
             + (is_col ? WSUM_W'(cs_cur) : '0);
    priority if (s1_q.three_rows && three_cols) begin
      s2_d.div = DIV_9;
    end else if (s1_q.three_rows || three_cols) begin
      s2_d.div = DIV_6;
    end else begin
      s2_d.div = DIV_4;
    end
    s2_d.last_burst = s1_q.last_burst;
    s2_d.last_image = s1_q.last_image;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && is_col) begin
      cs1_q <= cs_cur;
      cs2_q <= cs1_q;
    end
    if (s1_valid_q) s2_q <= s2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by 4, 6 or 9 through a reciprocal multiply
  // --------------------------------------------------------------------------
  logic [RECIP_W-1:0]        recip;
  logic [WSUM_W+RECIP_W-1:0] prod;
  out_t                      res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q & s1_q.emit;
    end
  end

  always_comb begin
    unique case (s2_q.div)
      DIV_4:   recip = MUL_4;
      DIV_6:   recip = MUL_6;
      DIV_9:   recip = MUL_9;
      default: recip = MUL_4;
    endcase
    prod = (WSUM_W+RECIP_W)'(s2_q.sum) * (WSUM_W+RECIP_W)'(recip);
    res.value      = prod[RECIP_SHIFT +: PIX_W];
    res.last_burst = s2_q.last_burst;
    res.last_image = s2_q.last_image;
  end

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  out_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic             fifo_push, fifo_pop;
  out_t             head;

  assign fifo_push     = s2_valid_q;
  assign fifo_pop      = m_axis_tvalid & m_axis_tready;
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tdata  = head.value;
  assign m_axis_tlast  = head.last_burst;
  assign m_axis_tuser  = head.last_image;

  always_ff @(posedge clk_i) begin
    if (fifo_push) fifo_q[wr_ptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (fifo_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({fifo_push, fifo_pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
        2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEVER(a_fifo_overflow, fifo_push && !fifo_pop && fifo_cnt_q == CNT_W'(FIFO_DEPTH), "output queue overflow")
  `ASSERT_NEVER(a_mem_same_addr, mem_we && mem_re && mem_waddr == mem_raddr, "line memory read and write collide")
  `ASSERT_NEXT(a_row_end_tail, in_acc && row_q != '0 && col_q == last_idx, state_q == ST_TAIL, "row end without tail")
  `ASSERT_IMPL(a_image_end_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "image end not last of burst")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clipped 3x3 box filter.
// Streams square images of random and extreme pixels through the slave side
// and programs image_size over APB while the block is idle. A local smoothing
// model keeps its own line buffers and raster position and queues the means
// that each accepted pixel beat releases. Every result beat on the master
// side is checked field by field against the oldest queued mean, under
// random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  import bfcm_pkg::*;

  localparam int REG_SPARE     = 1;       // unmapped register slot, writes ignored
  localparam int SETTLE_CYCLES = 10;      // pipeline depth plus margin
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [PIX_W-1:0] line_t [MAX_SIZE];

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last_burst;
    logic             last_image;
  } smoothed_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [PIX_W-1:0]  s_axis_tdata;   // [7:0] pixel_in
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [PIX_W-1:0]  m_axis_tdata;   // [7:0] smoothed_value
  logic              m_axis_tlast;   // last_of_burst
  logic              m_axis_tuser;   // last_of_image

  // Smoothing model state: two finished rows above the one being filled.
  line_t             row_above2;
  line_t             row_above1;
  line_t             row_filling;
  int                row_pos;
  int                col_pos;
  logic [SIZE_W-1:0] size_reg;

  smoothed_t         smoothed_q[$];   // means still owed by the block
  int                error_count;
  int                cycle_count;
  int                idle_pct;        // chance in 100 that the source idles
  int                stall_pct;       // chance in 100 that the sink stalls

  box_filter_3x3_clipped_mean i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run; counts rising edges from time zero.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Sink side: toggle tready at random per the current stall rate.
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Smoothing model
  // --------------------------------------------------------------------------

  // Clamp the programmed side length to the supported range.
  function automatic int active_size();
    int n;
    n = int'(size_reg);
    if (n < 2) n = 2;
    if (n > MAX_SIZE) n = MAX_SIZE;
    return n;
  endfunction

  // Truncated mean over the window around col, clipped at the left and right
  // edges; rows missing above or below drop out of both sum and count.
  function automatic logic [PIX_W-1:0] clipped_mean(input line_t top, input line_t mid,
                                                    input line_t bot, input bit has_top,
                                                    input bit has_bot, input int col,
                                                    input int n);
    int lo;
    int hi;
    int sum;
    int cnt;
    lo  = (col > 0) ? col - 1 : 0;
    hi  = (col + 1 < n) ? col + 1 : n - 1;
    sum = 0;
    cnt = 0;
    for (int x = lo; x <= hi; x++) begin
      sum += mid[x];
      cnt++;
      if (has_top) begin
        sum += top[x];
        cnt++;
      end
      if (has_bot) begin
        sum += bot[x];
        cnt++;
      end
    end
    return PIX_W'(sum / cnt);
  endfunction

  function automatic void owe_mean(input logic [PIX_W-1:0] value, input logic last_image);
    smoothed_q.push_back('{value: value, last_burst: 1'b0, last_image: last_image});
  endfunction

  // Advance the model by one accepted pixel and queue the means it releases.
  task automatic take_pixel(input logic [PIX_W-1:0] pix);
    int n;
    int row;
    int col;
    int burst_start;
    n           = active_size();
    row         = row_pos;
    col         = col_pos;
    burst_start = smoothed_q.size();
    if (row >= n || col >= n) begin
      row = 0;
      col = 0;
    end
    row_filling[col] = pix;

    // Row 0 only fills the buffers; later rows release the row above.
    if (row >= 1) begin
      if (col >= 1)
        owe_mean(clipped_mean(row_above2, row_above1, row_filling, row >= 2, 1'b1,
                              col - 1, n), 1'b0);
      // Right edge of the row above needs no pixel to its right.
      if (col == n - 1)
        owe_mean(clipped_mean(row_above2, row_above1, row_filling, row >= 2, 1'b1,
                              col, n), 1'b0);
      // Bottom-right pixel: flush the whole bottom row, no row below it.
      if (row == n - 1 && col == n - 1) begin
        for (int x = 0; x < n; x++)
          owe_mean(clipped_mean(row_above1, row_filling, row_filling, 1'b1, 1'b0, x, n),
                   x == n - 1);
      end
    end
    if (smoothed_q.size() > burst_start)
      smoothed_q[smoothed_q.size() - 1].last_burst = 1'b1;

    col++;
    if (col >= n) begin
      col        = 0;
      row_above2 = row_above1;
      row_above1 = row_filling;
      row++;
      if (row >= n) row = 0;
    end
    row_pos = row;
    col_pos = col;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Compare each result beat with the oldest owed mean.
  always @(posedge clk_i) begin
    smoothed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (smoothed_q.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata, -1);
      end else begin
        want = smoothed_q.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("smoothed_value", m_axis_tdata, want.value);
        if (m_axis_tlast !== want.last_burst)
          report_mismatch("last_of_burst", m_axis_tlast, want.last_burst);
        if (m_axis_tuser !== want.last_image)
          report_mismatch("last_of_image", m_axis_tuser, want.last_image);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one pixel beat, with random idle cycles ahead of it, and hold it
  // until taken. tvalid stays high afterwards so back-to-back beats need no
  // second assignment in the same step.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    take_pixel(pix);
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Drain every owed mean, then let the line-memory pipeline settle.
  task automatic wait_idle();
    hold_input();
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, then access phase until pready.
  task automatic apb_transfer(input int index, input logic write,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_W'(index * 4);
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_image_size(input logic [SIZE_W-1:0] want);
    logic [DATA_W-1:0] rdata;
    apb_transfer(int'(REG_IMAGE_SIZE), 1'b0, '0, rdata);
    if (rdata !== DATA_W'(want))
      report_mismatch("image_size readback", rdata, want);
  endtask

  // Register write; image_size also restarts the raster position.
  task automatic write_reg(input int index, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rdata;
    apb_transfer(index, 1'b1, data, rdata);
    if (index == int'(REG_IMAGE_SIZE)) begin
      size_reg = data[SIZE_W-1:0];
      row_pos  = 0;
      col_pos  = 0;
      check_image_size(size_reg);
    end
  endtask

  // Bias toward the rails so saturated windows show up often.
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_value();
    check_image_size(SIZE_RESET);
  endtask

  // Sizes 0 and 1 act as 2: corners only, divisor 4 everywhere.
  task automatic test_clamped_low_sizes();
    write_reg(int'(REG_IMAGE_SIZE), 0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    wait_idle();
    write_reg(int'(REG_IMAGE_SIZE), 1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
  endtask

  // Write the unmapped slot mid-image: the raster position must survive.
  // All-ones pixels give the largest full-window sum.
  task automatic test_spare_register_write();
    wait_idle();
    write_reg(int'(REG_IMAGE_SIZE), 3);
    repeat (4) send_pixel(8'd255);
    wait_idle();
    write_reg(REG_SPARE, 32'h2A);
    repeat (5) send_pixel(8'd255);
  endtask

  // Abandon an image halfway: a size write restarts at row 0.
  task automatic test_restart_mid_image();
    repeat (5) send_pixel(random_pixel());
    wait_idle();
    write_reg(int'(REG_IMAGE_SIZE), 2);
    repeat (4) send_pixel(random_pixel());
  endtask

  // Small images of random size and content; now and then an image is cut
  // short, and once per phase the source waits until the sink has caught up.
  task automatic test_random_images(input int idle, input int stall, input int budget);
    int sent;
    int raw;
    int n;
    int len;
    int pause_at;
    wait_idle();
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    pause_at  = $urandom_range(budget - 10, 5);
    while (sent < budget) begin
      wait_idle();
      case ($urandom_range(9))
        0:       raw = $urandom_range(1, 0);
        1:       raw = 2;
        default: raw = $urandom_range(7, 2);
      endcase
      write_reg(int'(REG_IMAGE_SIZE), raw);
      n = (raw < 2) ? 2 : raw;
      repeat ($urandom_range(2, 1)) begin
        len = n * n;
        if ($urandom_range(5) == 0) len = $urandom_range(n * n - 1, 1);
        for (int p = 0; p < len && sent < budget; p++) begin
          if (sent == pause_at) begin
            hold_input();
            while (smoothed_q.size() != 0) @(posedge clk_i);
          end
          send_pixel(random_pixel());
          sent++;
        end
      end
    end
  endtask

  // Full-width rows: the top row is released by the second one, whose end
  // carries the right-edge result; a few pixels of the third row follow.
  task automatic test_largest_image();
    wait_idle();
    idle_pct  = 25;
    stall_pct = 25;
    write_reg(int'(REG_IMAGE_SIZE), 63);
    repeat (2 * MAX_SIZE + 4) send_pixel(random_pixel());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    size_reg      = SIZE_RESET;
    row_pos       = 0;
    col_pos       = 0;
    error_count   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      row_above2[i]  = '0;
      row_above1[i]  = '0;
      row_filling[i] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_value();
    test_clamped_low_sizes();
    test_spare_register_write();
    test_restart_mid_image();
    test_random_images(0, 0, 20);
    test_random_images(49, 0, 20);
    test_random_images(0, 49, 20);
    test_random_images(25, 25, 20);
    test_largest_image();

    // Drain, then give stray beats a chance to show up.
    hold_input();
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
